// ===== rtl/ow_pkg.sv =====
package ow_pkg;

    localparam int OpWidth = 3;
    localparam int ByteWidth = 8;
    localparam int TickWidth = 11;
    localparam int BitIdxWidth = 4;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 10;

    localparam logic [ByteWidth-1:0] CrcPoly = 8'h8C;

    typedef enum logic [OpWidth-1:0] {
        OP_NONE       = 3'd0,
        OP_BUS_RESET  = 3'd1,
        OP_WRITE_BIT  = 3'd2,
        OP_READ_BIT   = 3'd3,
        OP_WRITE_BYTE = 3'd4,
        OP_READ_BYTE  = 3'd5
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_SHORT_LOW     = 3'd3,
        REG_LONG_LOW      = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_SLOT          = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_RST_LOW  = 5'b00010,
        PH_RST_WAIT = 5'b00100,
        PH_RST_TAIL = 5'b01000,
        PH_SLOT     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [5:0] short_low_us;
        logic [6:0] long_low_us;
        logic [6:0] read_sample_us;
        logic [7:0] slot_us;
    } timing_cfg_t;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [ByteWidth-1:0] read_data;
        logic [ByteWidth-1:0] crc_value;
    } result_t;

    localparam logic [9:0] ResetLowDefault = 10'd480;
    localparam logic [7:0] PresenceWaitDefault = 8'd70;
    localparam logic [9:0] ResetTailDefault = 10'd410;
    localparam logic [5:0] ShortLowDefault = 6'd6;
    localparam logic [6:0] LongLowDefault = 7'd60;
    localparam logic [6:0] ReadSampleDefault = 7'd15;
    localparam logic [7:0] SlotDefault = 8'd70;

    // Dallas CRC-8, reflected, one byte folded in bit by bit.
    function automatic logic [ByteWidth-1:0] crc8_byte(
        input logic [ByteWidth-1:0] crc_in,
        input logic [ByteWidth-1:0] data
    );
        logic [ByteWidth-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < ByteWidth; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPoly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/ow_cfg_regs.sv =====
module ow_cfg_regs
    import ow_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output timing_cfg_t             timing_cfg
);

    timing_cfg_t cfg_reg;
    timing_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign timing_cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_RESET_LOW:     cfg_next.reset_low_us = cfg_data[9:0];
                REG_PRESENCE_WAIT: cfg_next.presence_wait_us = cfg_data[7:0];
                REG_RESET_TAIL:    cfg_next.reset_tail_us = cfg_data[9:0];
                REG_SHORT_LOW:     cfg_next.short_low_us = cfg_data[5:0];
                REG_LONG_LOW:      cfg_next.long_low_us = cfg_data[6:0];
                REG_READ_SAMPLE:   cfg_next.read_sample_us = cfg_data[6:0];
                REG_SLOT:          cfg_next.slot_us = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us <= ResetLowDefault;
            cfg_reg.presence_wait_us <= PresenceWaitDefault;
            cfg_reg.reset_tail_us <= ResetTailDefault;
            cfg_reg.short_low_us <= ShortLowDefault;
            cfg_reg.long_low_us <= LongLowDefault;
            cfg_reg.read_sample_us <= ReadSampleDefault;
            cfg_reg.slot_us <= SlotDefault;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/ow_seq.sv =====
module ow_seq
    import ow_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [OpWidth-1:0]   operation,
    input  logic [ByteWidth-1:0] write_data,
    input  logic                 line_level,
    input  timing_cfg_t          timing_cfg,
    output result_t              result
);

    phase_t                 phase_reg, phase_next, ph_cur;
    logic [TickWidth-1:0]   tick_reg, tick_next, tc_cur, tc_inc;
    logic [BitIdxWidth-1:0] bit_idx_reg, bit_idx_next, bi_cur, bi_inc;
    logic [ByteWidth-1:0]   shift_reg, shift_next, sb_cur, sb_mod;
    logic [OpWidth-1:0]     cmd_reg, cmd_next, cmd_cur;
    logic                   presence_reg, presence_next;
    logic [ByteWidth-1:0]   crc_reg, crc_next, crc_cur;
    logic [ByteWidth-1:0]   read_reg, read_next;
    logic                   is_read, is_byte, cur_bit, drive, done;
    logic [6:0]             low_time;
    logic [7:0]             slot_len, sample_len;

    always_comb begin
        ph_cur = phase_reg;
        tc_cur = tick_reg;
        bi_cur = bit_idx_reg;
        sb_cur = shift_reg;
        cmd_cur = cmd_reg;
        crc_cur = crc_reg;
        if (phase_reg == PH_IDLE) begin
            if (op_t'(operation) == OP_BUS_RESET) begin
                cmd_cur = operation;
                ph_cur = PH_RST_LOW;
                tc_cur = '0;
                crc_cur = '0;
            end else if (op_t'(operation) == OP_WRITE_BIT || op_t'(operation) == OP_READ_BIT
                      || op_t'(operation) == OP_WRITE_BYTE
                      || op_t'(operation) == OP_READ_BYTE) begin
                cmd_cur = operation;
                ph_cur = PH_SLOT;
                tc_cur = '0;
                bi_cur = '0;
                sb_cur = (op_t'(operation) == OP_WRITE_BIT
                       || op_t'(operation) == OP_WRITE_BYTE) ? write_data : '0;
            end
        end

        is_read = (op_t'(cmd_cur) == OP_READ_BIT) || (op_t'(cmd_cur) == OP_READ_BYTE);
        is_byte = (op_t'(cmd_cur) == OP_WRITE_BYTE) || (op_t'(cmd_cur) == OP_READ_BYTE);
        cur_bit = sb_cur[bi_cur[2:0]];
        low_time = (is_read || cur_bit) ? {1'b0, timing_cfg.short_low_us}
                                        : timing_cfg.long_low_us;
        slot_len = timing_cfg.slot_us;
        if ({1'b0, low_time} > slot_len) begin
            slot_len = {1'b0, low_time};
        end
        sample_len = {1'b0, timing_cfg.read_sample_us} + 8'd1;
        if (is_read && sample_len > slot_len) begin
            slot_len = sample_len;
        end
        tc_inc = tc_cur + 11'd1;
        bi_inc = bi_cur + 4'd1;
        sb_mod = sb_cur;

        phase_next = ph_cur;
        tick_next = tc_cur;
        bit_idx_next = bi_cur;
        shift_next = sb_cur;
        cmd_next = cmd_cur;
        crc_next = crc_cur;
        presence_next = presence_reg;
        read_next = read_reg;
        drive = 1'b0;
        done = 1'b0;

        unique case (ph_cur)
            PH_RST_LOW: begin
                drive = 1'b1;
                tick_next = tc_inc;
                if (tc_inc >= {1'b0, timing_cfg.reset_low_us}) begin
                    phase_next = PH_RST_WAIT;
                    tick_next = '0;
                end
            end
            PH_RST_WAIT: begin
                if (tc_cur >= {3'b0, timing_cfg.presence_wait_us}) begin
                    presence_next = ~line_level;
                    if (timing_cfg.reset_tail_us <= 10'd1) begin
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end else begin
                        phase_next = PH_RST_TAIL;
                        tick_next = 11'd1;
                    end
                end else begin
                    tick_next = tc_inc;
                end
            end
            PH_RST_TAIL: begin
                tick_next = tc_inc;
                if (tc_inc >= {1'b0, timing_cfg.reset_tail_us}) begin
                    phase_next = PH_IDLE;
                    done = 1'b1;
                end
            end
            PH_SLOT: begin
                drive = tc_cur < {4'b0, low_time};
                if (is_read && tc_cur == {4'b0, timing_cfg.read_sample_us}) begin
                    sb_mod[bi_cur[2:0]] = line_level;
                end
                shift_next = sb_mod;
                if (tc_inc >= {3'b0, slot_len}) begin
                    bit_idx_next = bi_inc;
                    tick_next = '0;
                    if (bi_inc >= (is_byte ? 4'd8 : 4'd1)) begin
                        if (op_t'(cmd_cur) == OP_READ_BIT) begin
                            read_next = {7'b0, sb_mod[0]};
                        end
                        if (op_t'(cmd_cur) == OP_READ_BYTE) begin
                            read_next = sb_mod;
                            crc_next = crc8_byte(crc_cur, sb_mod);
                        end
                        bit_idx_next = '0;
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                end else begin
                    tick_next = tc_inc;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        result.drive_low = drive;
        result.busy_res = (phase_next != PH_IDLE);
        result.done_res = done;
        result.presence = presence_next;
        result.read_data = read_next;
        result.crc_value = crc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg <= '0;
            bit_idx_reg <= '0;
            shift_reg <= '0;
            cmd_reg <= '0;
            presence_reg <= 1'b0;
            crc_reg <= '0;
            read_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg <= shift_next;
            cmd_reg <= cmd_next;
            presence_reg <= presence_next;
            crc_reg <= crc_next;
            read_reg <= read_next;
        end
    end

endmodule

// ===== rtl/onewire_bus_master_unit.sv =====
// Each accepted item is held in the input register and its result item is captured in the result register.
// Throughput: one item per cycle unless m_tready stalls; the sequencer state advances once per item.
// The input register and the result register stall only on m_tready.
// Reset (aresetn low, synchronous) clears the sequencer to idle, presence, read data
// and CRC to zero, and loads the timing registers with their defaults.
module onewire_bus_master_unit
    import ow_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,  // write_data[7:0], line_level[8], zero
    input  logic [OpWidth-1:0]      s_tuser,  // operation[2:0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // drive_low[0], busy_res[1], done_res[2], presence[3], read_data[11:4],
    // crc_value[19:12], zero
    output logic [23:0]             m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    logic                 in_valid_reg;
    logic [OpWidth-1:0]   in_op_reg;
    logic [ByteWidth-1:0] in_data_reg;
    logic                 in_line_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              step_result;
    timing_cfg_t          timing_cfg;
    logic                 step_fire;

    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'b0, out_reg.crc_value, out_reg.read_data, out_reg.presence,
                      out_reg.done_res, out_reg.busy_res, out_reg.drive_low};

    ow_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .timing_cfg (timing_cfg)
    );

    ow_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_fire),
        .operation  (in_op_reg),
        .write_data (in_data_reg),
        .line_level (in_line_reg),
        .timing_cfg (timing_cfg),
        .result     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg <= s_tuser;
            in_data_reg <= s_tdata[7:0];
            in_line_reg <= s_tdata[8];
        end
        if (step_fire) begin
            out_reg <= step_result;
        end
    end

endmodule

// ===== tb/onewire_bus_master_unit_tb.sv =====
`timescale 1ns / 100ps

module onewire_bus_master_unit_tb
    import ow_pkg::*;
();

    localparam logic [OpWidth-1:0] OpReserved6 = 3'd6;
    localparam logic [OpWidth-1:0] OpReserved7 = 3'd7;
    localparam logic [CfgIdxWidth-1:0] RegUnused = 3'd7;
    localparam int LineLow = 0;
    localparam int LineHigh = 1;
    localparam int LineRandom = 2;
    localparam int HoldoffCycles = 400;

    typedef struct packed {
        logic [OpWidth-1:0] op;
        logic [7:0]         wd;
        logic               line;
    } bus_tick_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [15:0]             s_tdata = '0;
    logic [OpWidth-1:0]      s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [23:0]             m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;

    bus_tick_t   tick_queue[$];
    result_t     expected_bus_state[$];
    bus_tick_t   tx_tick;
    result_t     want;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          holdoff_left = 0;
    logic        holdoff_used = 1'b0;
    logic        holdoff_request = 1'b0;
    logic        no_idle = 1'b0;
    int          ticks_pushed = 0;
    int          ticks_taken = 0;
    int          error_count = 0;

    // Shadow of the bus sequencer and its timing registers.
    timing_cfg_t timing;
    phase_t      seq_phase;
    op_t         cur_cmd;
    int unsigned tick_cnt;
    int unsigned bit_idx;
    logic [7:0]  shift_reg;
    logic        presence_q;
    logic [7:0]  crc_q;
    logic [7:0]  read_q;

    onewire_bus_master_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = acc[0] ^ data[k];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CrcPoly;
            end
        end
        return acc;
    endfunction

    function automatic result_t advance_bus(input logic [OpWidth-1:0] op, input logic [7:0] wd,
                                            input logic line);
        result_t     res;
        logic        is_read;
        logic [2:0]  bi;
        int unsigned nbits;
        int unsigned low;
        int unsigned span;
        res = '0;
        if (seq_phase == PH_IDLE) begin
            if (op == OP_BUS_RESET) begin
                cur_cmd = OP_BUS_RESET;
                seq_phase = PH_RST_LOW;
                tick_cnt = 0;
                crc_q = '0;
            end else if (op >= OP_WRITE_BIT && op <= OP_READ_BYTE) begin
                cur_cmd = op_t'(op);
                seq_phase = PH_SLOT;
                tick_cnt = 0;
                bit_idx = 0;
                shift_reg = (op == OP_WRITE_BIT || op == OP_WRITE_BYTE) ? wd : 8'd0;
            end
        end
        case (seq_phase)
            PH_RST_LOW: begin
                res.drive_low = 1'b1;
                tick_cnt++;
                if (tick_cnt >= 32'(timing.reset_low_us)) begin
                    seq_phase = PH_RST_WAIT;
                    tick_cnt = 0;
                end
            end
            PH_RST_WAIT: begin
                if (tick_cnt >= 32'(timing.presence_wait_us)) begin
                    presence_q = ~line;
                    if (timing.reset_tail_us <= 10'd1) begin
                        seq_phase = PH_IDLE;
                        res.done_res = 1'b1;
                    end else begin
                        seq_phase = PH_RST_TAIL;
                        tick_cnt = 1;
                    end
                end else begin
                    tick_cnt++;
                end
            end
            PH_RST_TAIL: begin
                tick_cnt++;
                if (tick_cnt >= 32'(timing.reset_tail_us)) begin
                    seq_phase = PH_IDLE;
                    res.done_res = 1'b1;
                end
            end
            PH_SLOT: begin
                is_read = (cur_cmd == OP_READ_BIT) || (cur_cmd == OP_READ_BYTE);
                nbits = (cur_cmd == OP_WRITE_BYTE || cur_cmd == OP_READ_BYTE) ? 8 : 1;
                bi = bit_idx[2:0];
                if (is_read || shift_reg[bi]) begin
                    low = 32'(timing.short_low_us);
                end else begin
                    low = 32'(timing.long_low_us);
                end
                span = 32'(timing.slot_us);
                if (low > span) begin
                    span = low;
                end
                if (is_read && 32'(timing.read_sample_us) + 32'd1 > span) begin
                    span = 32'(timing.read_sample_us) + 32'd1;
                end
                res.drive_low = (tick_cnt < low);
                if (is_read && tick_cnt == 32'(timing.read_sample_us)) begin
                    shift_reg[bi] = line;
                end
                if (tick_cnt + 32'd1 >= span) begin
                    bit_idx++;
                    tick_cnt = 0;
                    if (bit_idx >= nbits) begin
                        if (cur_cmd == OP_READ_BIT) begin
                            read_q = {7'd0, shift_reg[0]};
                        end
                        if (cur_cmd == OP_READ_BYTE) begin
                            read_q = shift_reg;
                            crc_q = crc_fold(crc_q, shift_reg);
                        end
                        bit_idx = 0;
                        seq_phase = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                end else begin
                    tick_cnt++;
                end
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
        res.busy_res = (seq_phase != PH_IDLE);
        res.presence = presence_q;
        res.read_data = read_q;
        res.crc_value = crc_q;
        return res;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 65) begin
            return 0;
        end
        if (pick < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic compare_field(input string label, input logic [7:0] expected_val,
                                 input logic [7:0] actual_val);
        if (actual_val !== expected_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, label, expected_val, actual_val);
            error_count++;
        end
    endtask

    task automatic push_tick(input logic [OpWidth-1:0] op, input logic [7:0] wd,
                             input logic line);
        bus_tick_t item;
        item.op = op;
        item.wd = wd;
        item.line = line;
        tick_queue.push_back(item);
        ticks_pushed++;
    endtask

    // Issues one command, then idle ticks until the command has finished.
    task automatic run_command(input logic [OpWidth-1:0] op, input logic [7:0] wd,
                               input int mode);
        logic running;
        logic line;
        running = 1'b1;
        @(negedge aclk);
        line = (mode == LineRandom) ? 1'($urandom_range(0, 1)) : (mode == LineHigh);
        push_tick(op, wd, line);
        while (running) begin
            while (ticks_taken != ticks_pushed) begin
                @(negedge aclk);
            end
            if (seq_phase == PH_IDLE) begin
                running = 1'b0;
            end else begin
                line = (mode == LineRandom) ? 1'($urandom_range(0, 1)) : (mode == LineHigh);
                push_tick(OP_NONE, 8'($urandom), line);
            end
        end
    endtask

    task automatic random_traffic(input int count, input logic steady);
        int pick;
        logic [OpWidth-1:0] op;
        @(negedge aclk);
        no_idle = steady;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                op = OpWidth'($urandom_range(OP_BUS_RESET, OP_READ_BYTE));
            end else if (pick < 14) begin
                op = OpWidth'($urandom_range(OpReserved6, OpReserved7));
            end else begin
                op = OP_NONE;
            end
            push_tick(op, 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || expected_bus_state.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [9:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic load_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                               input logic [9:0] rst_tail, input logic [9:0] low_short,
                               input logic [9:0] low_long, input logic [9:0] sample,
                               input logic [9:0] slot_len);
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRESENCE_WAIT, pres_wait);
        write_reg(REG_RESET_TAIL, rst_tail);
        write_reg(REG_SHORT_LOW, low_short);
        write_reg(REG_LONG_LOW, low_long);
        write_reg(REG_READ_SAMPLE, sample);
        write_reg(REG_SLOT, slot_len);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            tx_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap > 0 || tick_queue.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end
            end else begin
                tx_tick = tick_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, tx_tick.line, tx_tick.wd};
                s_tuser <= tx_tick.op;
                tx_gap = idle_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
            holdoff_left = 0;
            holdoff_used = 1'b0;
        end else if (holdoff_request && !holdoff_used) begin
            holdoff_used = 1'b1;
            holdoff_left = HoldoffCycles;
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap = idle_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RESET_LOW:     timing.reset_low_us = cfg_data[9:0];
                    REG_PRESENCE_WAIT: timing.presence_wait_us = cfg_data[7:0];
                    REG_RESET_TAIL:    timing.reset_tail_us = cfg_data[9:0];
                    REG_SHORT_LOW:     timing.short_low_us = cfg_data[5:0];
                    REG_LONG_LOW:      timing.long_low_us = cfg_data[6:0];
                    REG_READ_SAMPLE:   timing.read_sample_us = cfg_data[6:0];
                    REG_SLOT:          timing.slot_us = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_bus_state.push_back(advance_bus(s_tuser, s_tdata[7:0], s_tdata[8]));
                ticks_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bus_state.size() == 0) begin
                    $display("%0t ns: result item with none expected, %s %h",
                             $time, "expected nothing, actual", m_tdata);
                    error_count++;
                end else begin
                    want = expected_bus_state.pop_front();
                    compare_field("drive_low", 8'(want.drive_low), 8'(m_tdata[0]));
                    compare_field("busy", 8'(want.busy_res), 8'(m_tdata[1]));
                    compare_field("done", 8'(want.done_res), 8'(m_tdata[2]));
                    compare_field("presence", 8'(want.presence), 8'(m_tdata[3]));
                    compare_field("read_data", want.read_data, m_tdata[11:4]);
                    compare_field("crc", want.crc_value, m_tdata[19:12]);
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int base_count;
        int round;
        timing.reset_low_us = ResetLowDefault;
        timing.presence_wait_us = PresenceWaitDefault;
        timing.reset_tail_us = ResetTailDefault;
        timing.short_low_us = ShortLowDefault;
        timing.long_low_us = LongLowDefault;
        timing.read_sample_us = ReadSampleDefault;
        timing.slot_us = SlotDefault;
        seq_phase = PH_IDLE;
        cur_cmd = OP_NONE;
        tick_cnt = 0;
        bit_idx = 0;
        shift_reg = '0;
        presence_q = 1'b0;
        crc_q = '0;
        read_q = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Timing after reset.
        run_command(OP_WRITE_BIT, 8'h00, LineRandom);
        run_command(OP_READ_BIT, 8'h00, LineRandom);

        wait_quiet();
        load_timing(10'd3, 10'd2, 10'd3, 10'd1, 10'd4, 10'd2, 10'd5);
        run_command(OP_BUS_RESET, 8'h00, LineHigh);
        run_command(OP_WRITE_BYTE, 8'h00, LineRandom);
        run_command(OP_WRITE_BYTE, 8'hFF, LineRandom);
        run_command(OP_WRITE_BIT, 8'hFE, LineRandom);
        run_command(OP_WRITE_BIT, 8'h01, LineRandom);
        run_command(OP_READ_BIT, 8'h00, LineHigh);
        run_command(OP_READ_BYTE, 8'h00, LineRandom);
        run_command(OP_READ_BYTE, 8'h00, LineLow);
        run_command(OpReserved6, 8'hFF, LineRandom);
        run_command(OpReserved7, 8'hFF, LineRandom);
        run_command(OP_NONE, 8'hFF, LineRandom);
        // A command offered while another runs must be dropped.
        @(negedge aclk);
        push_tick(OP_WRITE_BYTE, 8'h5A, 1'b1);
        run_command(OP_READ_BYTE, 8'h00, LineRandom);
        run_command(OP_BUS_RESET, 8'h00, LineLow);

        // Slots shorter than the low time and the read sample point.
        wait_quiet();
        load_timing(10'd2, 10'd1, 10'd2, 10'd9, 10'd20, 10'd12, 10'd3);
        run_command(OP_READ_BIT, 8'h00, LineRandom);
        run_command(OP_WRITE_BIT, 8'h00, LineRandom);
        run_command(OP_READ_BYTE, 8'h00, LineRandom);
        run_command(OP_WRITE_BYTE, 8'($urandom), LineRandom);

        wait_quiet();
        load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_command(OP_WRITE_BYTE, 8'hC3, LineRandom);
        run_command(OP_READ_BYTE, 8'h00, LineRandom);
        run_command(OP_BUS_RESET, 8'h00, LineLow);
        run_command(OP_READ_BIT, 8'h00, LineLow);

        wait_quiet();
        load_timing(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        write_reg(RegUnused, 10'($urandom));
        run_command(OP_READ_BIT, 8'h00, LineRandom);

        for (round = 0; round < 5; round++) begin
            wait_quiet();
            load_timing(10'($urandom_range(0, 20)), 10'($urandom_range(0, 8)),
                        10'($urandom_range(0, 10)), 10'($urandom_range(0, 6)),
                        10'($urandom_range(0, 12)), 10'($urandom_range(0, 10)),
                        10'($urandom_range(0, 14)));
            base_count = ticks_taken;
            random_traffic(100, round == 2);
            if (round == 0) begin
                while (ticks_taken < base_count + 40) begin
                    @(negedge aclk);
                end
                holdoff_request = 1'b1;
            end
            run_command(OP_NONE, 8'h00, LineRandom);
        end

        wait_quiet();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
